// ===== sv/alc_pkg.sv =====
// Shared types, constants and the power-curve ROM for the ambient light classifier.
// Used by alc_regs, alc_ctrl, alc_dp and the top level; depends on nothing.
`timescale 1ns / 1ps

package alc_pkg;

  // Default fixed-point formats
  localparam int RATIO_FRAC_BITS_DEF = 10;
  localparam int LUX_FRAC_BITS_DEF   = 8;

  // Field widths
  localparam int COUNT_W    = 16;
  localparam int LUX_W      = 24;
  localparam int CLASS_W    = 3;
  localparam int TMODE_W    = 5;
  localparam int NUM_LIMITS = 7;

  // Configuration port
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_TIMING_MODE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT_FIRST = 3'd1;

  typedef logic [NUM_LIMITS-1:0][LUX_W-1:0] limit_arr_t;

  localparam logic [TMODE_W-1:0] TMODE_RST = 5'd2;
  localparam limit_arr_t LIMIT_RST = {
    24'd12800000, 24'd2560000, 24'd256000, 24'd51200, 24'd12800, 24'd2560, 24'd256
  };

  // timing_mode decode
  localparam int TMODE_GAIN_BIT = 4;
  localparam logic [1:0] INTEG_13MS  = 2'd0;
  localparam logic [1:0] INTEG_101MS = 2'd1;
  localparam int GAIN_SHIFT = 4;

  // Payload types
  typedef struct packed {
    logic [COUNT_W-1:0] visible_count;
    logic [COUNT_W-1:0] infrared_count;
  } alc_in_t;

  typedef struct packed {
    logic [LUX_W-1:0]   lux_value;
    logic [CLASS_W-1:0] light_class;
    logic               was_held;
  } alc_out_t;

  typedef struct packed {
    logic [TMODE_W-1:0] timing_mode;
    limit_arr_t         limit;
  } alc_cfg_t;

  // Controller to datapath
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RDIV_INIT,
    OP_DIV_STEP,
    OP_SEG,
    OP_MUL0,
    OP_MUL1,
    OP_MUL2,
    OP_LDIV_INIT,
    OP_FINISH,
    OP_HOLD
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } alc_cmd_t;

  typedef struct packed {
    logic both_zero;
  } alc_sts_t;

  typedef enum logic [1:0] {
    SEG_POW,
    SEG_MID,
    SEG_HIGH,
    SEG_TOP
  } seg_e;

  // Shared radix-2 divider
  localparam int REM_W       = 23;
  localparam int DVD_W       = 24;
  localparam int LDIV_STEPS  = 24;
  localparam int STEP_CNT_W  = 5;

  // Shared multiplier
  localparam int MUL_A_W = 37;
  localparam int MUL_B_W = 16;
  localparam int MUL_W   = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 28;

  // Segment coefficients, 1e-5 lux per count
  localparam logic [ACC_W-1:0]   K_POW_V  = 28'd199229440;  // 3040 * 2^16
  localparam logic [MUL_B_W-1:0] K_POW_P  = 16'd6200;
  localparam logic [MUL_B_W-1:0] K_MID_V  = 16'd2240;
  localparam logic [MUL_B_W-1:0] K_MID_R  = 16'd3100;
  localparam logic [MUL_B_W-1:0] K_HIGH_V = 16'd1280;
  localparam logic [MUL_B_W-1:0] K_HIGH_R = 16'd1530;
  localparam logic [MUL_B_W-1:0] K_TOP_V  = 16'd146;
  localparam logic [MUL_B_W-1:0] K_TOP_R  = 16'd112;

  // Integration scale: numerator and fden * 1e5
  localparam logic [MUL_B_W-1:0] F_NUM = 16'd322;
  localparam logic [MUL_B_W-1:0] F_ONE = 16'd1;
  localparam logic [REM_W-1:0] DEN_13MS  = 23'd1100000;
  localparam logic [REM_W-1:0] DEN_101MS = 23'd8100000;
  localparam logic [REM_W-1:0] DEN_UNIT  = 23'd100000;

  // ratio^1.4 table: entry i = floor((i/1024)^1.4 * 2^16)
  localparam int POW_ROM_DEPTH = 513;
  localparam int POW_IDX_W     = 10;
  localparam int POW_W         = 15;

  typedef logic [POW_W-1:0] pow_rom_t [POW_ROM_DEPTH];

  // Largest y with y^5 <= i^7 * 2^10, found bit by bit.
  function automatic pow_rom_t gen_pow_rom();
    pow_rom_t rom;
    logic [79:0] rhs;
    logic [79:0] c5;
    logic [POW_W-1:0] y;
    logic [POW_W-1:0] c;
    for (int i = 0; i < POW_ROM_DEPTH; i++) begin
      rhs = 80'(i);
      for (int k = 1; k < 7; k++) begin
        rhs = rhs * 80'(i);
      end
      rhs = rhs << 10;
      y = '0;
      for (int bt = POW_W - 1; bt >= 0; bt--) begin
        c = y | (POW_W'(1) << bt);
        c5 = 80'(c) * 80'(c) * 80'(c) * 80'(c) * 80'(c);
        if (c5 <= rhs) begin
          y = c;
        end
      end
      rom[i] = y;
    end
    return rom;
  endfunction

endpackage

// ===== sv/alc_regs.sv =====
// Configuration register file behind an APB-style port.
// Depends on alc_pkg for register indexes, reset values and the config struct.
`timescale 1ns / 1ps

module alc_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [alc_pkg::PADDR_W-1:0]   paddr,
  input  logic [alc_pkg::PDATA_W-1:0]   pwdata,
  output logic [alc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output alc_pkg::alc_cfg_t             cfg_o
);

  logic [alc_pkg::TMODE_W-1:0]   timing_q;
  alc_pkg::limit_arr_t           limit_q;
  logic [alc_pkg::REG_IDX_W-1:0] idx;
  logic [alc_pkg::REG_IDX_W-1:0] lim_idx;
  logic                          wr_en;

  assign idx     = paddr[alc_pkg::PADDR_W-1:2];
  assign lim_idx = idx - alc_pkg::REG_LIMIT_FIRST;
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timing_q <= alc_pkg::TMODE_RST;
      limit_q  <= alc_pkg::LIMIT_RST;
    end else if (wr_en) begin
      if (idx == alc_pkg::REG_TIMING_MODE) begin
        timing_q <= pwdata[alc_pkg::TMODE_W-1:0];
      end else begin
        limit_q[lim_idx] <= pwdata[alc_pkg::LUX_W-1:0];
      end
    end
  end

  always_comb begin
    if (idx == alc_pkg::REG_TIMING_MODE) begin
      prdata = alc_pkg::PDATA_W'(timing_q);
    end else begin
      prdata = alc_pkg::PDATA_W'(limit_q[lim_idx]);
    end
  end

  assign cfg_o.timing_mode = timing_q;
  assign cfg_o.limit       = limit_q;

endmodule

// ===== sv/alc_dp.sv =====
// Datapath: input capture, shared radix-2 divider, shared multiplier, power ROM,
// lux scaling, classification, held result and output register. Uses alc_pkg.
`timescale 1ns / 1ps

module alc_dp #(
  parameter int RATIO_FRAC_BITS = alc_pkg::RATIO_FRAC_BITS_DEF,
  parameter int LUX_FRAC_BITS   = alc_pkg::LUX_FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  alc_pkg::alc_cmd_t cmd_i,
  output alc_pkg::alc_sts_t sts_o,
  input  alc_pkg::alc_in_t  in_data_i,
  input  alc_pkg::alc_cfg_t cfg_i,
  output alc_pkg::alc_out_t out_data_o
);

  localparam int Q_W = RATIO_FRAC_BITS + 1;
  localparam logic [Q_W-1:0] T50  = Q_W'(1 << (RATIO_FRAC_BITS - 1));
  localparam logic [Q_W-1:0] T61  = Q_W'((61 << RATIO_FRAC_BITS) / 100);
  localparam logic [Q_W-1:0] T80  = Q_W'((80 << RATIO_FRAC_BITS) / 100);
  localparam logic [Q_W-1:0] T130 = Q_W'((130 << RATIO_FRAC_BITS) / 100);
  localparam int X_W         = alc_pkg::MUL_A_W + LUX_FRAC_BITS;
  localparam int POW_SH_BASE = 16 - LUX_FRAC_BITS;
  localparam int IDX_EXT_W   = RATIO_FRAC_BITS + alc_pkg::POW_IDX_W;
  localparam alc_pkg::pow_rom_t POW_ROM = alc_pkg::gen_pow_rom();

  logic [alc_pkg::COUNT_W-1:0] v_q, r_q;
  logic [alc_pkg::REM_W-1:0]   rem_q, dsr_q;
  logic [alc_pkg::DVD_W-1:0]   dvd_q, quo_q;
  alc_pkg::seg_e               seg_q;
  logic                        zero_q, sat_q;
  logic [alc_pkg::POW_W-1:0]   p_q;
  logic [alc_pkg::ACC_W-1:0]   acc_q;
  logic [alc_pkg::MUL_W-1:0]   mul_q;
  logic [alc_pkg::LUX_W-1:0]   held_lux_q;
  logic [alc_pkg::CLASS_W-1:0] held_class_q;
  alc_pkg::alc_out_t           out_q;

  // Ratio, segment and ROM index
  logic [Q_W-1:0]                q;
  logic [IDX_EXT_W-1:0]          idx_ext;
  logic [alc_pkg::POW_IDX_W-1:0] rom_idx;
  alc_pkg::seg_e                 seg_d;

  assign q       = quo_q[Q_W-1:0];
  assign idx_ext = {q[RATIO_FRAC_BITS-1:0], alc_pkg::POW_IDX_W'(0)} >> RATIO_FRAC_BITS;
  assign rom_idx = (q <= T50) ? idx_ext[alc_pkg::POW_IDX_W-1:0] : '0;

  always_comb begin
    if (q <= T50) begin
      seg_d = alc_pkg::SEG_POW;
    end else if (q <= T61) begin
      seg_d = alc_pkg::SEG_MID;
    end else if (q <= T80) begin
      seg_d = alc_pkg::SEG_HIGH;
    end else begin
      seg_d = alc_pkg::SEG_TOP;
    end
  end

  // Timing mode decode
  logic                        gain;
  logic [alc_pkg::MUL_B_W-1:0] fnum;
  logic [alc_pkg::REM_W-1:0]   den;

  assign gain = cfg_i.timing_mode[alc_pkg::TMODE_GAIN_BIT];

  always_comb begin
    case (cfg_i.timing_mode[1:0])
      alc_pkg::INTEG_13MS: begin
        fnum = alc_pkg::F_NUM;
        den  = alc_pkg::DEN_13MS;
      end
      alc_pkg::INTEG_101MS: begin
        fnum = alc_pkg::F_NUM;
        den  = alc_pkg::DEN_101MS;
      end
      default: begin
        fnum = alc_pkg::F_ONE;
        den  = alc_pkg::DEN_UNIT;
      end
    endcase
  end

  // Segment coefficients
  logic [alc_pkg::MUL_B_W-1:0] coef_v, coef_r;

  always_comb begin
    case (seg_q)
      alc_pkg::SEG_MID: begin
        coef_v = alc_pkg::K_MID_V;
        coef_r = alc_pkg::K_MID_R;
      end
      alc_pkg::SEG_HIGH: begin
        coef_v = alc_pkg::K_HIGH_V;
        coef_r = alc_pkg::K_HIGH_R;
      end
      default: begin
        coef_v = alc_pkg::K_TOP_V;
        coef_r = alc_pkg::K_TOP_R;
      end
    endcase
  end

  // Shared multiplier operands
  logic                        is_pow;
  logic [alc_pkg::ACC_W-1:0]   k0, lin_diff;
  logic                        lin_pos;
  logic [alc_pkg::MUL_A_W-1:0] mul_a;
  logic [alc_pkg::MUL_B_W-1:0] mul_b;
  logic [alc_pkg::MUL_W-1:0]   mul_p;

  assign is_pow   = (seg_q == alc_pkg::SEG_POW);
  assign k0       = alc_pkg::K_POW_V - mul_q[alc_pkg::ACC_W-1:0];
  assign lin_pos  = acc_q > mul_q[alc_pkg::ACC_W-1:0];
  assign lin_diff = acc_q - mul_q[alc_pkg::ACC_W-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      alc_pkg::OP_MUL0: begin
        if (is_pow) begin
          mul_a = alc_pkg::MUL_A_W'(p_q);
          mul_b = alc_pkg::K_POW_P;
        end else begin
          mul_a = alc_pkg::MUL_A_W'(v_q);
          mul_b = coef_v;
        end
      end
      alc_pkg::OP_MUL1: begin
        if (is_pow) begin
          mul_a = alc_pkg::MUL_A_W'(k0);
          mul_b = fnum;
        end else begin
          mul_a = alc_pkg::MUL_A_W'(r_q);
          mul_b = coef_r;
        end
      end
      alc_pkg::OP_MUL2: begin
        if (is_pow) begin
          mul_a = mul_q[alc_pkg::MUL_A_W-1:0];
          mul_b = v_q;
        end else begin
          mul_a = alc_pkg::MUL_A_W'(lin_diff);
          mul_b = fnum;
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = alc_pkg::MUL_W'(mul_a) * alc_pkg::MUL_W'(mul_b);

  // Scaled numerator: the power segment drops 2^(16+g-LFB), the linear ones gain 2^(LFB-g)
  logic [X_W-1:0] x_pow, x_lin, x, x_hi;
  logic           sat_d;

  assign x_pow = X_W'(mul_q >> (gain ? POW_SH_BASE + alc_pkg::GAIN_SHIFT : POW_SH_BASE));
  assign x_lin = X_W'(mul_q[alc_pkg::MUL_A_W-1:0])
                 << (gain ? LUX_FRAC_BITS - alc_pkg::GAIN_SHIFT : LUX_FRAC_BITS);
  assign x     = is_pow ? x_pow : x_lin;
  assign x_hi  = x >> alc_pkg::DVD_W;
  assign sat_d = x_hi >= X_W'(den);

  // Divider step: one quotient bit per cycle
  logic [alc_pkg::REM_W:0]   rem_sh, dsr_ext, rem_sub;
  logic                      div_ge;
  logic [alc_pkg::REM_W-1:0] rem_nx;

  assign rem_sh  = {rem_q, dvd_q[alc_pkg::DVD_W-1]};
  assign dsr_ext = {1'b0, dsr_q};
  assign div_ge  = rem_sh >= dsr_ext;
  assign rem_sub = rem_sh - dsr_ext;
  assign rem_nx  = div_ge ? rem_sub[alc_pkg::REM_W-1:0] : rem_sh[alc_pkg::REM_W-1:0];

  // Final lux and class
  logic [alc_pkg::LUX_W-1:0]   lux_fin;
  logic [alc_pkg::CLASS_W-1:0] cls;

  always_comb begin
    if (zero_q) begin
      lux_fin = '0;
    end else if (sat_q) begin
      lux_fin = '1;
    end else begin
      lux_fin = quo_q[alc_pkg::LUX_W-1:0];
    end
  end

  // First limit the lux value is below wins
  always_comb begin
    cls = alc_pkg::CLASS_W'(alc_pkg::NUM_LIMITS);
    for (int k = alc_pkg::NUM_LIMITS - 1; k >= 0; k--) begin
      if (lux_fin < cfg_i.limit[k]) begin
        cls = alc_pkg::CLASS_W'(k);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      alc_pkg::OP_LOAD: begin
        v_q <= in_data_i.visible_count;
        r_q <= in_data_i.infrared_count;
      end
      alc_pkg::OP_RDIV_INIT: begin
        // q stays below 2^(RFB+1) unless r >= 2v, which gives zero lux anyway
        rem_q  <= alc_pkg::REM_W'(r_q >> 1);
        dvd_q  <= {r_q[0], (alc_pkg::DVD_W - 1)'(0)};
        dsr_q  <= alc_pkg::REM_W'(v_q);
        quo_q  <= '0;
        zero_q <= {1'b0, r_q} >= {v_q, 1'b0};
      end
      alc_pkg::OP_DIV_STEP: begin
        rem_q <= rem_nx;
        dvd_q <= dvd_q << 1;
        quo_q <= {quo_q[alc_pkg::DVD_W-2:0], div_ge};
      end
      alc_pkg::OP_SEG: begin
        seg_q  <= seg_d;
        p_q    <= POW_ROM[rom_idx];
        zero_q <= zero_q || (q > T130);
      end
      alc_pkg::OP_MUL0: begin
        mul_q <= mul_p;
      end
      alc_pkg::OP_MUL1: begin
        acc_q <= mul_q[alc_pkg::ACC_W-1:0];
        mul_q <= mul_p;
      end
      alc_pkg::OP_MUL2: begin
        mul_q  <= mul_p;
        zero_q <= zero_q || (!is_pow && !lin_pos);
      end
      alc_pkg::OP_LDIV_INIT: begin
        rem_q <= alc_pkg::REM_W'(x_hi);
        dvd_q <= x[alc_pkg::DVD_W-1:0];
        dsr_q <= den;
        quo_q <= '0;
        sat_q <= sat_d;
      end
      alc_pkg::OP_FINISH: begin
        out_q.lux_value   <= lux_fin;
        out_q.light_class <= cls;
        out_q.was_held    <= 1'b0;
      end
      alc_pkg::OP_HOLD: begin
        out_q.lux_value   <= held_lux_q;
        out_q.light_class <= held_class_q;
        out_q.was_held    <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_lux_q   <= '0;
      held_class_q <= '0;
    end else if (cmd_i.op == alc_pkg::OP_FINISH) begin
      held_lux_q   <= lux_fin;
      held_class_q <= cls;
    end
  end

  assign sts_o.both_zero = (v_q == '0) && (r_q == '0);
  assign out_data_o      = out_q;

endmodule

// ===== sv/alc_ctrl.sv =====
// Sequencer for one reading: capture, ratio divide, segment pick, three multiplies,
// lux divide and result write. Drives the datapath through alc_pkg command codes.
`timescale 1ns / 1ps

module alc_ctrl #(
  parameter int RATIO_FRAC_BITS = alc_pkg::RATIO_FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output alc_pkg::alc_cmd_t cmd_o,
  input  alc_pkg::alc_sts_t sts_i
);

  localparam int RDIV_STEPS = RATIO_FRAC_BITS + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RINIT = 4'd1;
  localparam logic [3:0] S_RDIV  = 4'd2;
  localparam logic [3:0] S_SEG   = 4'd3;
  localparam logic [3:0] S_MUL0  = 4'd4;
  localparam logic [3:0] S_MUL1  = 4'd5;
  localparam logic [3:0] S_MUL2  = 4'd6;
  localparam logic [3:0] S_LINIT = 4'd7;
  localparam logic [3:0] S_LDIV  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]                     state_q, state_d;
  logic [alc_pkg::STEP_CNT_W-1:0] cnt_q, cnt_d;
  logic                           hold_q, hold_d;
  logic                           out_valid_q, out_valid_d;
  logic                           out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    hold_d      = hold_q;
    out_valid_d = out_valid_q;
    cmd_o.op    = alc_pkg::OP_NONE;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = alc_pkg::OP_LOAD;
          state_d  = S_RINIT;
        end
      end
      S_RINIT: begin
        if (sts_i.both_zero) begin
          hold_d  = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.op = alc_pkg::OP_RDIV_INIT;
          hold_d   = 1'b0;
          cnt_d    = '0;
          state_d  = S_RDIV;
        end
      end
      S_RDIV: begin
        cmd_o.op = alc_pkg::OP_DIV_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == alc_pkg::STEP_CNT_W'(RDIV_STEPS - 1)) begin
          state_d = S_SEG;
        end
      end
      S_SEG: begin
        cmd_o.op = alc_pkg::OP_SEG;
        state_d  = S_MUL0;
      end
      S_MUL0: begin
        cmd_o.op = alc_pkg::OP_MUL0;
        state_d  = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.op = alc_pkg::OP_MUL1;
        state_d  = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.op = alc_pkg::OP_MUL2;
        state_d  = S_LINIT;
      end
      S_LINIT: begin
        cmd_o.op = alc_pkg::OP_LDIV_INIT;
        cnt_d    = '0;
        state_d  = S_LDIV;
      end
      S_LDIV: begin
        cmd_o.op = alc_pkg::OP_DIV_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == alc_pkg::STEP_CNT_W'(alc_pkg::LDIV_STEPS - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          cmd_o.op    = hold_q ? alc_pkg::OP_HOLD : alc_pkg::OP_FINISH;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      hold_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      hold_q      <= hold_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_RINIT))
    else $error("accepted beat did not start a reading");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == alc_pkg::OP_FINISH || cmd_o.op == alc_pkg::OP_HOLD) |-> out_free)
    else $error("result written over an untaken beat");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished result not presented");

  a_rdiv_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RDIV) |-> (cnt_q < alc_pkg::STEP_CNT_W'(RDIV_STEPS)))
    else $error("ratio divide ran past its step count");

endmodule

// ===== sv/ambient_light_lux_classifier.sv =====
// Ambient light classifier: each reading goes through the ratio divide, segment pick,
// three multiplies and lux divide before its result is valid; a reading with both counts
// zero skips these and returns the held result. One reading is worked at a time: the next
// can be taken in the cycle after the result is written. The radix-2 divider does the ratio
// and then the 24-bit lux quotient. Reset restores the registers to their defaults and
// clears the held result to zero lux, total darkness; no clearing pass follows.
`timescale 1ns / 1ps

module ambient_light_lux_classifier #(
  parameter int RATIO_FRAC_BITS = alc_pkg::RATIO_FRAC_BITS_DEF,
  parameter int LUX_FRAC_BITS   = alc_pkg::LUX_FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  alc_pkg::alc_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output alc_pkg::alc_out_t           out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [alc_pkg::PADDR_W-1:0] paddr,
  input  logic [alc_pkg::PDATA_W-1:0] pwdata,
  output logic [alc_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  alc_pkg::alc_cfg_t cfg;
  alc_pkg::alc_cmd_t cmd;
  alc_pkg::alc_sts_t sts;

  alc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  alc_ctrl #(
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  alc_dp #(
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS),
    .LUX_FRAC_BITS   (LUX_FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg),
    .out_data_o (out_data_o)
  );

endmodule
